// ===== hw/rtl/chessboard_serial_message_parser_core_assert.svh =====
// assertion macros shared by the parser checker
`ifndef CHESSBOARD_SERIAL_MESSAGE_PARSER_CORE_ASSERT_SVH
`define CHESSBOARD_SERIAL_MESSAGE_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define CSMP_CHECK_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSMP_CHECK_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/csmp_pkg.sv =====
// types, codes and helper functions of the chessboard serial message parser
`timescale 1ns / 1ps

package csmp_pkg;

   // operations passed from the framing front to the executing back
   typedef logic [2:0] op_code_type;
   localparam op_code_type OP_STRAY   = 3'd0;
   localparam op_code_type OP_BADLEN  = 3'd1;
   localparam op_code_type OP_START   = 3'd2;
   localparam op_code_type OP_UNKNOWN = 3'd3;
   localparam op_code_type OP_DUMP    = 3'd4;
   localparam op_code_type OP_FIELD   = 3'd5;
   localparam op_code_type OP_CLOCK   = 3'd6;

   // result kinds
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_DUMP       = 3'd0;
   localparam kind_type KIND_CHANGE     = 3'd1;
   localparam kind_type KIND_CLOCK      = 3'd2;
   localparam kind_type KIND_STRAY      = 3'd3;
   localparam kind_type KIND_BAD_LENGTH = 3'd4;
   localparam kind_type KIND_UNKNOWN    = 3'd5;
   localparam kind_type KIND_BAD_SQUARE = 3'd6;

   typedef struct packed {
      op_code_type code;
      logic [5:0]  index;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      kind_type          event_kind;
      logic [5:0]        square;
      logic signed [3:0] piece;
      logic [15:0]       black_seconds;
      logic [15:0]       white_seconds;
      logic              clock_running;
      logic              white_to_move;
      logic [7:0]        bad_value;
   } result_type;

   // rotation 0 flips rank order, rotation 1 flips file order
   function automatic logic [5:0] map_square(input logic [5:0] s, input logic rotated);
      return rotated ? (s ^ 6'd7) : (s ^ 6'd56);
   endfunction

   // board piece code to signed piece, codes above 12 are empty
   function automatic logic signed [3:0] map_piece(input logic [7:0] code);
      logic signed [3:0] p;
      p = 4'sd0;
      if (code[7:4] == 4'd0) begin
         case (code[3:0])
            4'd1:    p = 4'sd1;
            4'd2:    p = 4'sd6;
            4'd3:    p = 4'sd2;
            4'd4:    p = 4'sd5;
            4'd5:    p = 4'sd3;
            4'd6:    p = 4'sd7;
            4'd7:    p = -4'sd1;
            4'd8:    p = -4'sd6;
            4'd9:    p = -4'sd2;
            4'd10:   p = -4'sd5;
            4'd11:   p = -4'sd3;
            4'd12:   p = -4'sd7;
            default: p = 4'sd0;
         endcase
      end
      return p;
   endfunction

   // two bcd digits, nibbles above nine used as they are
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
   endfunction

endpackage

// ===== hw/rtl/csmp_fifo.sv =====
// small register queue used between the parser stages and at the result side
`timescale 1ns / 1ps

module csmp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/csmp_front.sv =====
// framing front: hunts headers, tracks length and payload position, classifies bytes
`timescale 1ns / 1ps

module csmp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [7:0]      rx_byte,
   output logic            op_valid,
   output csmp_pkg::op_type op
);

   import csmp_pkg::*;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_LEN_HI  = 2'd1;
   localparam logic [1:0] PH_LEN_LO  = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [6:0] CMD_RESET  = 7'h00;
   localparam logic [6:0] CMD_DUMP   = 7'h06;
   localparam logic [6:0] CMD_CLOCK  = 7'h0d;
   localparam logic [6:0] CMD_FIELD  = 7'h0e;
   localparam logic [6:0] CMD_SERIAL = 7'h0f;
   localparam logic [6:0] CMD_TRADE  = 7'h11;
   localparam logic [6:0] CMD_VER    = 7'h12;
   localparam logic [6:0] CMD_LONG   = 7'h13;

   logic [1:0]  phase_ff, phase_in;
   logic [6:0]  command_ff, command_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [6:0]  index_ff, index_in;      // saturates at 64
   logic [15:0] length;
   logic        known;

   always_comb begin
      length = {1'b0, length_high_ff, 7'd0} + {8'd0, rx_byte};
      known  = command_ff inside {CMD_RESET, CMD_DUMP, CMD_CLOCK, CMD_FIELD,
                                  CMD_SERIAL, CMD_TRADE, CMD_VER, CMD_LONG};

      phase_in       = phase_ff;
      command_in     = command_ff;
      length_high_in = length_high_ff;
      remaining_in   = remaining_ff;
      index_in       = index_ff;
      op_valid       = 1'b0;
      op.code        = OP_STRAY;
      op.index       = index_ff[5:0];
      op.data        = rx_byte;

      if (in_valid) begin
         case (phase_ff)
            PH_HUNT: begin
               if (!rx_byte[7]) begin
                  op_valid = 1'b1;
                  op.code  = OP_STRAY;
               end else begin
                  command_in = rx_byte[6:0];
                  phase_in   = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               length_high_in = rx_byte;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               op_valid = 1'b1;
               if (length < 16'd3) begin
                  op.code  = OP_BADLEN;
                  phase_in = PH_HUNT;
               end else begin
                  remaining_in = length - 16'd3;
                  index_in     = '0;
                  phase_in     = (length == 16'd3) ? PH_HUNT : PH_PAYLOAD;
                  op.code      = known ? OP_START : OP_UNKNOWN;
                  op.data      = {1'b0, command_ff};
               end
            end
            PH_PAYLOAD: begin
               remaining_in = remaining_ff - 1'b1;
               if (remaining_ff == 16'd1) begin
                  phase_in = PH_HUNT;
               end
               if (!index_ff[6]) begin
                  index_in = index_ff + 1'b1;
               end
               // only bytes that a command still uses go on
               if (command_ff == CMD_DUMP && !index_ff[6]) begin
                  op_valid = 1'b1;
                  op.code  = OP_DUMP;
               end else if (command_ff == CMD_FIELD && index_ff < 7'd2) begin
                  op_valid = 1'b1;
                  op.code  = OP_FIELD;
               end else if (command_ff == CMD_CLOCK && index_ff < 7'd7) begin
                  op_valid = 1'b1;
                  op.code  = OP_CLOCK;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         command_ff     <= '0;
         length_high_ff <= '0;
         remaining_ff   <= '0;
         index_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         command_ff     <= command_in;
         length_high_ff <= length_high_in;
         remaining_ff   <= remaining_in;
         index_ff       <= index_in;
      end
   end

endmodule

// ===== hw/rtl/csmp_back.sv =====
// executing back: clock accumulation, field update tracking and result forming
`timescale 1ns / 1ps

module csmp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                board_rotated,
   input  logic                op_valid,
   input  csmp_pkg::op_type    op,
   output logic                op_ready,
   input  logic                res_full,
   output logic                res_valid,
   output csmp_pkg::result_type res
);

   import csmp_pkg::*;

   logic [15:0] black_ff, black_in;
   logic [15:0] white_ff, white_in;
   logic [5:0]  pending_ff, pending_in;
   logic        failed_ff, failed_in;
   logic [7:0]  digits;
   logic        take;

   assign op_ready = !res_full;
   assign take     = op_valid && !res_full;

   always_comb begin
      digits     = bcd_value(op.data);
      black_in   = black_ff;
      white_in   = white_ff;
      pending_in = pending_ff;
      failed_in  = failed_ff;
      res_valid  = 1'b0;
      res        = '0;

      if (take) begin
         case (op.code)
            OP_STRAY: begin
               res_valid      = 1'b1;
               res.event_kind = KIND_STRAY;
               res.bad_value  = op.data;
            end
            OP_BADLEN: begin
               res_valid      = 1'b1;
               res.event_kind = KIND_BAD_LENGTH;
               res.bad_value  = op.data;
            end
            OP_START: begin
               black_in  = '0;
               white_in  = '0;
               failed_in = 1'b0;
            end
            OP_UNKNOWN: begin
               black_in       = '0;
               white_in       = '0;
               failed_in      = 1'b0;
               res_valid      = 1'b1;
               res.event_kind = KIND_UNKNOWN;
               res.bad_value  = op.data;
            end
            OP_DUMP: begin
               res_valid      = 1'b1;
               res.event_kind = KIND_DUMP;
               res.square     = map_square(op.index, board_rotated);
               res.piece      = map_piece(op.data);
            end
            OP_FIELD: begin
               if (op.index == 6'd0) begin
                  if (op.data > 8'd63) begin
                     failed_in      = 1'b1;
                     res_valid      = 1'b1;
                     res.event_kind = KIND_BAD_SQUARE;
                     res.bad_value  = op.data;
                  end else begin
                     pending_in = op.data[5:0];
                  end
               end else if (!failed_ff) begin
                  res_valid      = 1'b1;
                  res.event_kind = KIND_CHANGE;
                  res.square     = map_square(pending_ff, board_rotated);
                  res.piece      = map_piece(op.data);
               end
            end
            OP_CLOCK: begin
               case (op.index)
                  6'd0: black_in = 16'({12'd0, digits[3:0]} * 16'd3600);
                  6'd1: black_in = black_ff + 16'({8'd0, digits} * 16'd60);
                  6'd2: black_in = black_ff + {8'd0, digits};
                  6'd3: white_in = 16'({12'd0, digits[3:0]} * 16'd3600);
                  6'd4: white_in = white_ff + 16'({8'd0, digits} * 16'd60);
                  6'd5: white_in = white_ff + {8'd0, digits};
                  default: begin
                     res_valid         = 1'b1;
                     res.event_kind    = KIND_CLOCK;
                     res.black_seconds = black_ff;
                     res.white_seconds = white_ff;
                     res.clock_running = op.data[0];
                     res.white_to_move = op.data[1];
                  end
               endcase
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         black_ff   <= '0;
         white_ff   <= '0;
         pending_ff <= '0;
         failed_ff  <= 1'b0;
      end else begin
         black_ff   <= black_in;
         white_ff   <= white_in;
         pending_ff <= pending_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

// ===== hw/rtl/chessboard_serial_message_parser_core.sv =====
// top level of the chessboard serial message parser
`timescale 1ns / 1ps
// takes one received byte per cycle, sustained, as long as the command queue has room
// a request's result reaches the rsp ports through the front into the command queue,
// then through the back into the result queue
// synchronous active-high reset clears parse state, both queues and the rotation setting

module chessboard_serial_message_parser_core #(
   parameter int CMD_QUEUE_DEPTH    = 2,
   parameter int RESULT_QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,

   // request side
   input  logic              push,
   output logic              full,
   input  logic [7:0]        req_rx_byte,

   // result side
   output logic              empty,
   input  logic              pop,
   output logic [2:0]        rsp_event_kind,
   output logic [5:0]        rsp_square,
   output logic signed [3:0] rsp_piece,
   output logic [15:0]       rsp_black_seconds,
   output logic [15:0]       rsp_white_seconds,
   output logic              rsp_clock_running,
   output logic              rsp_white_to_move,
   output logic [7:0]        rsp_bad_value,

   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   import csmp_pkg::*;

   // rotation register, word 0 of the register map
   logic rotated_ff, rotated_in;
   logic csr_write;

   // front to command queue
   logic   req_take;
   logic   front_valid;
   op_type front_op;

   // command queue to back
   op_type cmd_head;
   logic   cmd_empty;
   logic   back_ready;

   // back to result queue
   logic       res_valid;
   logic       res_full;
   result_type res_entry;
   result_type res_head;

   // configuration port, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign rotated_in = csr_write ? pwdata[0] : rotated_ff;
   assign prdata    = (paddr[2] == 1'b0) ? {31'd0, rotated_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotated_ff <= 1'b0;
      end else begin
         rotated_ff <= rotated_in;
      end
   end

   // a request is taken whenever the command queue has room
   assign req_take = push && !full;

   // front: framing and classification of each received byte
   csmp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_take),
      .rx_byte  (req_rx_byte),
      .op_valid (front_valid),
      .op       (front_op)
   );

   // command queue decouples framing from execution
   csmp_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_op),
      .pop       (back_ready),
      .pop_data  (cmd_head),
      .full      (full),
      .empty     (cmd_empty)
   );

   // back: carries out one queued operation per cycle while results have room
   csmp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .board_rotated (rotated_ff),
      .op_valid      (!cmd_empty),
      .op            (cmd_head),
      .op_ready      (back_ready),
      .res_full      (res_full),
      .res_valid     (res_valid),
      .res           (res_entry)
   );

   // result queue holds finished results until popped
   csmp_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_entry),
      .pop       (pop),
      .pop_data  (res_head),
      .full      (res_full),
      .empty     (empty)
   );

   // oldest result on the ports
   assign rsp_event_kind    = res_head.event_kind;
   assign rsp_square        = res_head.square;
   assign rsp_piece         = res_head.piece;
   assign rsp_black_seconds = res_head.black_seconds;
   assign rsp_white_seconds = res_head.white_seconds;
   assign rsp_clock_running = res_head.clock_running;
   assign rsp_white_to_move = res_head.white_to_move;
   assign rsp_bad_value     = res_head.bad_value;

endmodule

// ===== hw/rtl/csmp_checker.sv =====
// port-level checks of the parser, bound to the top level
`timescale 1ns / 1ps
`include "chessboard_serial_message_parser_core_assert.svh"

module csmp_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input logic [2:0]        rsp_event_kind,
   input logic [5:0]        rsp_square,
   input logic signed [3:0] rsp_piece,
   input logic [15:0]       rsp_black_seconds,
   input logic [15:0]       rsp_white_seconds,
   input logic              rsp_clock_running,
   input logic              rsp_white_to_move,
   input logic [7:0]        rsp_bad_value
);

   import csmp_pkg::*;

   `CSMP_CHECK_NEXT(a_reset_drains, clock, 1'b0, reset, empty && !full, "queues not empty after reset")

   `CSMP_CHECK_NOW(a_kind_range, clock, reset, !empty, rsp_event_kind <= KIND_BAD_SQUARE, "result kind out of range")

   `CSMP_CHECK_NOW(a_clock_fields, clock, reset, !empty && rsp_event_kind != KIND_CLOCK, rsp_black_seconds == 16'd0 && rsp_white_seconds == 16'd0 && !rsp_clock_running && !rsp_white_to_move, "clock fields set on a non-clock result")

   `CSMP_CHECK_NOW(a_square_fields, clock, reset, !empty && (rsp_event_kind == KIND_DUMP || rsp_event_kind == KIND_CHANGE), rsp_bad_value == 8'd0 && rsp_piece != 4'sb1000, "square result carries an error value or bad piece")

   `CSMP_CHECK_NEXT(a_result_held, clock, reset, !empty && !pop, !empty && $stable(rsp_event_kind) && $stable(rsp_square) && $stable(rsp_bad_value), "waiting result changed before pop")

endmodule

bind chessboard_serial_message_parser_core csmp_checker u_csmp_checker (.*);

// ===== sim/chessboard_serial_message_parser_core_tb.sv =====
// self-checking testbench of the chessboard serial message parser core
`timescale 1ns / 1ps

module chessboard_serial_message_parser_core_tb;
   import csmp_pkg::*;

   // register map: board_rotated is register 0
   localparam logic [2:0] ADDR_BOARD_ROTATED = 3'd0;

   // command codes of the board link
   localparam logic [6:0] CMD_QUIET_00 = 7'h00;
   localparam logic [6:0] CMD_DUMP     = 7'h06;
   localparam logic [6:0] CMD_CLOCK    = 7'h0d;
   localparam logic [6:0] CMD_FIELD    = 7'h0e;
   localparam logic [6:0] CMD_QUIET_0F = 7'h0f;
   localparam logic [6:0] CMD_QUIET_11 = 7'h11;
   localparam logic [6:0] CMD_QUIET_12 = 7'h12;
   localparam logic [6:0] CMD_QUIET_13 = 7'h13;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN_HIGH,
      PH_LEN_LOW,
      PH_PAYLOAD
   } frame_phase_t;

   // one row of the directed table; typed rows carry their own expectation
   typedef struct {
      logic [7:0] data;
      bit         typed;
      bit         typed_hit;
      result_type typed_event;
   } stim_row_t;

   logic              clock;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_rx_byte = 8'd0;
   logic              empty;
   logic              pop = 1'b0;
   logic [2:0]        rsp_event_kind;
   logic [5:0]        rsp_square;
   logic signed [3:0] rsp_piece;
   logic [15:0]       rsp_black_seconds;
   logic [15:0]       rsp_white_seconds;
   logic              rsp_clock_running;
   logic              rsp_white_to_move;
   logic [7:0]        rsp_bad_value;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = 3'd0;
   logic [31:0]       pwdata = 32'd0;
   logic [31:0]       prdata;
   logic              pready;

   chessboard_serial_message_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_square        (rsp_square),
      .rsp_piece         (rsp_piece),
      .rsp_black_seconds (rsp_black_seconds),
      .rsp_white_seconds (rsp_white_seconds),
      .rsp_clock_running (rsp_clock_running),
      .rsp_white_to_move (rsp_white_to_move),
      .rsp_bad_value     (rsp_bad_value),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // parser mirror state
   logic         rotation_setting;
   frame_phase_t phase;
   logic [6:0]   frame_cmd;
   logic [7:0]   len_high;
   logic [15:0]  bytes_left;
   logic [15:0]  byte_pos;
   logic [15:0]  black_acc;
   logic [15:0]  white_acc;
   logic [5:0]   held_square;
   bit           square_rejected;

   result_type   expected_events[$];
   stim_row_t    directed_rows[$];
   int           error_count = 0;
   int           items_sent = 0;
   int           results_seen = 0;
   int           burst_left = 0;
   int           stall_left = 0;
   int unsigned  rx_cycle = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the handshake hangs
   initial begin
      #20_000_000;
      $display("chessboard_serial_message_parser_core_tb: errors");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      // keep the log short when the block is badly broken
      if (error_count <= 100)
         $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("result %0d %s got %0h expected %0h",
                                results_seen, name, got, want));
   endtask

   function automatic bit is_known(input logic [6:0] c);
      return c == CMD_QUIET_00 || c == CMD_DUMP || c == CMD_CLOCK || c == CMD_FIELD ||
             c == CMD_QUIET_0F || c == CMD_QUIET_11 || c == CMD_QUIET_12 ||
             c == CMD_QUIET_13;
   endfunction

   // sensor square to engine square under the current rotation
   function automatic logic [5:0] orient(input logic [5:0] s);
      return rotation_setting ? {s[5:3], ~s[2:0]} : {~s[5:3], s[2:0]};
   endfunction

   function automatic logic signed [3:0] signed_piece(input logic [7:0] code);
      case (code)
         8'd1:    return 4'sd1;
         8'd2:    return 4'sd6;
         8'd3:    return 4'sd2;
         8'd4:    return 4'sd5;
         8'd5:    return 4'sd3;
         8'd6:    return 4'sd7;
         8'd7:    return -4'sd1;
         8'd8:    return -4'sd6;
         8'd9:    return -4'sd2;
         8'd10:   return -4'sd5;
         8'd11:   return -4'sd3;
         8'd12:   return -4'sd7;
         default: return 4'sd0;
      endcase
   endfunction

   // advance the framing mirror by one byte, returns 1 when a result is due
   function automatic bit parse_rx_byte(input logic [7:0] b, output result_type ev);
      logic [15:0] frame_len;
      logic [15:0] pos;
      logic [7:0]  digits;
      bit          hit;
      ev = '0;
      hit = 1'b0;
      case (phase)
         PH_HUNT: begin
            if (!b[7]) begin
               hit = 1'b1;
               ev.event_kind = KIND_STRAY;
               ev.bad_value = b;
            end else begin
               frame_cmd = b[6:0];
               phase = PH_LEN_HIGH;
            end
         end
         PH_LEN_HIGH: begin
            len_high = b;
            phase = PH_LEN_LOW;
         end
         PH_LEN_LOW: begin
            frame_len = {1'b0, len_high, 7'd0} + {8'd0, b};
            if (frame_len < 16'd3) begin
               phase = PH_HUNT;
               hit = 1'b1;
               ev.event_kind = KIND_BAD_LENGTH;
               ev.bad_value = b;
            end else begin
               bytes_left = frame_len - 16'd3;
               byte_pos = 16'd0;
               black_acc = 16'd0;
               white_acc = 16'd0;
               square_rejected = 1'b0;
               phase = (bytes_left != 16'd0) ? PH_PAYLOAD : PH_HUNT;
               if (!is_known(frame_cmd)) begin
                  hit = 1'b1;
                  ev.event_kind = KIND_UNKNOWN;
                  ev.bad_value = {1'b0, frame_cmd};
               end
            end
         end
         default: begin
            pos = byte_pos;
            if (byte_pos != 16'hffff) byte_pos++;
            if (bytes_left != 16'd0) bytes_left--;
            if (bytes_left == 16'd0) phase = PH_HUNT;
            // two bcd digits, nibbles above nine taken as they are
            digits = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
            case (frame_cmd)
               CMD_DUMP: begin
                  if (pos < 16'd64) begin
                     hit = 1'b1;
                     ev.event_kind = KIND_DUMP;
                     ev.square = orient(pos[5:0]);
                     ev.piece = signed_piece(b);
                  end
               end
               CMD_FIELD: begin
                  if (pos == 16'd0) begin
                     if (b > 8'd63) begin
                        square_rejected = 1'b1;
                        hit = 1'b1;
                        ev.event_kind = KIND_BAD_SQUARE;
                        ev.bad_value = b;
                     end else begin
                        held_square = b[5:0];
                     end
                  end else if (pos == 16'd1 && !square_rejected) begin
                     hit = 1'b1;
                     ev.event_kind = KIND_CHANGE;
                     ev.square = orient(held_square);
                     ev.piece = signed_piece(b);
                  end
               end
               CMD_CLOCK: begin
                  case (pos)
                     16'd0: black_acc = {12'd0, digits[3:0]} * 16'd3600;
                     16'd1: black_acc = black_acc + {8'd0, digits} * 16'd60;
                     16'd2: black_acc = black_acc + {8'd0, digits};
                     16'd3: white_acc = {12'd0, digits[3:0]} * 16'd3600;
                     16'd4: white_acc = white_acc + {8'd0, digits} * 16'd60;
                     16'd5: white_acc = white_acc + {8'd0, digits};
                     16'd6: begin
                        hit = 1'b1;
                        ev.event_kind = KIND_CLOCK;
                        ev.black_seconds = black_acc;
                        ev.white_seconds = white_acc;
                        ev.clock_running = b[0];
                        ev.white_to_move = b[1];
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
      endcase
      return hit;
   endfunction

   function automatic stim_row_t row(input logic [7:0] b);
      stim_row_t r;
      r.data = b;
      r.typed = 1'b0;
      r.typed_hit = 1'b0;
      r.typed_event = '0;
      return r;
   endfunction

   // framing byte that must give nothing
   function automatic stim_row_t row_none(input logic [7:0] b);
      stim_row_t r;
      r = row(b);
      r.typed = 1'b1;
      return r;
   endfunction

   function automatic stim_row_t row_err(input logic [7:0] b, input kind_type kind,
                                         input logic [7:0] bad);
      stim_row_t r;
      r = row_none(b);
      r.typed_hit = 1'b1;
      r.typed_event.event_kind = kind;
      r.typed_event.bad_value = bad;
      return r;
   endfunction

   function automatic logic [7:0] rand_piece_code();
      return ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 13));
   endfunction

   // one request through the queue handshake, with bursts and gaps
   task automatic send_byte(input stim_row_t r);
      result_type ev;
      bit         hit;
      int         gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 19) == 0) ? 200 : $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      push <= 1'b1;
      req_rx_byte <= r.data;
      @(posedge clock);
      while (full) @(posedge clock);
      hit = parse_rx_byte(r.data, ev);
      if (r.typed) begin
         hit = r.typed_hit;
         ev = r.typed_event;
      end
      if (hit) expected_events.push_back(ev);
      burst_left--;
      items_sent++;
   endtask

   // hold the sender until every expected result is back and the pipe is empty
   task automatic wait_idle();
      push <= 1'b0;
      burst_left = 0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write the rotation register, then read it back
   task automatic set_rotation(input logic value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_BOARD_ROTATED;
      pwdata <= {31'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      rotation_setting = value;
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[0] !== value)
         report_error($sformatf("board_rotated read back %0h expected %0h", prdata[0], value));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // mostly well-formed frames with random content, the rest noise
   task automatic send_random_frame();
      int          pick;
      int          n;
      int          cut;
      int          len;
      logic [6:0]  cmd;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [7:0]  body[$];
      pick = $urandom_range(0, 99);
      body = {};
      if (pick < 8) begin
         send_byte(row(8'($urandom_range(0, 127))));
         return;
      end
      if (pick < 14) begin
         // length below three
         send_byte(row(8'($urandom_range(128, 255))));
         send_byte(row(8'd0));
         send_byte(row(8'($urandom_range(0, 2))));
         return;
      end
      if (pick < 19) begin
         repeat ($urandom_range(1, 4)) send_byte(row(8'($urandom)));
         return;
      end
      if (pick < 42) begin
         cmd = CMD_DUMP;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
         repeat (n) body.push_back(rand_piece_code());
      end else if (pick < 62) begin
         cmd = CMD_FIELD;
         n = ($urandom_range(0, 3) != 0) ? 2 : $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            if (i == 0)
               body.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom_range(64, 255))
                                                          : 8'($urandom_range(0, 63)));
            else if (i == 1)
               body.push_back(rand_piece_code());
            else
               body.push_back(8'($urandom));
         end
      end else if (pick < 82) begin
         cmd = CMD_CLOCK;
         n = ($urandom_range(0, 3) != 0) ? 7 : $urandom_range(5, 9);
         for (int i = 0; i < n; i++) begin
            if (i < 6 && $urandom_range(0, 4) != 0)
               body.push_back({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))});
            else
               body.push_back(8'($urandom));
         end
      end else if (pick < 90) begin
         case ($urandom_range(0, 4))
            0:       cmd = CMD_QUIET_00;
            1:       cmd = CMD_QUIET_0F;
            2:       cmd = CMD_QUIET_11;
            3:       cmd = CMD_QUIET_12;
            default: cmd = CMD_QUIET_13;
         endcase
         repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
      end else begin
         do cmd = 7'($urandom); while (is_known(cmd));
         // now and then a long unknown frame so the high length byte matters
         n = ($urandom_range(0, 14) == 0) ? $urandom_range(128, 400) : $urandom_range(0, 5);
         repeat (n) body.push_back(8'($urandom));
      end
      len = body.size() + 3;
      hi = 8'(len >> 7);
      lo = 8'(len & 127);
      // same length spelled with the low byte above 127
      if (hi != 8'd0 && $urandom_range(0, 1) == 1) begin
         hi = hi - 8'd1;
         lo = lo + 8'd128;
      end
      send_byte(row({1'b1, cmd}));
      send_byte(row(hi));
      send_byte(row(lo));
      // a few frames are cut short, so the next header lands inside the payload
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size()) : body.size();
      for (int i = 0; i < cut; i++) send_byte(row(body[i]));
   endtask

   // result side: check what is popped, stall on a pattern that shifts over time
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && pop && !empty) begin
         results_seen++;
         if (expected_events.size() == 0) begin
            report_error($sformatf("result %0d kind %0d with nothing expected",
                                   results_seen, rsp_event_kind));
         end else begin
            want = expected_events.pop_front();
            compare_field("event_kind", {13'd0, rsp_event_kind}, {13'd0, want.event_kind});
            compare_field("square", {10'd0, rsp_square}, {10'd0, want.square});
            compare_field("piece", {12'd0, rsp_piece}, {12'd0, want.piece});
            compare_field("black_seconds", rsp_black_seconds, want.black_seconds);
            compare_field("white_seconds", rsp_white_seconds, want.white_seconds);
            compare_field("clock_running", {15'd0, rsp_clock_running},
                          {15'd0, want.clock_running});
            compare_field("white_to_move", {15'd0, rsp_white_to_move},
                          {15'd0, want.white_to_move});
            compare_field("bad_value", {8'd0, rsp_bad_value}, {8'd0, want.bad_value});
         end
      end
      rx_cycle++;
      case (rx_cycle[9:8])
         2'd0: pop <= 1'b1;
         2'd1: pop <= 1'($urandom_range(0, 1));
         2'd2: begin
            // long stalls now and then
            if (stall_left != 0) begin
               stall_left--;
               pop <= 1'b0;
            end else if ($urandom_range(0, 15) == 0) begin
               stall_left = $urandom_range(1, 25);
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
         default: pop <= (rx_cycle % 3 == 0);
      endcase
   end

   initial begin : stimulus
      int phase_goal;
      rotation_setting = 1'b0;
      phase = PH_HUNT;
      frame_cmd = 7'd0;
      len_high = 8'd0;
      bytes_left = 16'd0;
      byte_pos = 16'd0;
      black_acc = 16'd0;
      white_acc = 16'd0;
      held_square = 6'd0;
      square_rejected = 1'b0;

      // a stray byte, right after reset
      directed_rows.push_back(row_err(8'h00, KIND_STRAY, 8'h00));
      // length below three
      directed_rows.push_back(row_none(8'h86));
      directed_rows.push_back(row_none(8'h00));
      directed_rows.push_back(row_err(8'h02, KIND_BAD_LENGTH, 8'h02));
      // unknown command with the widest header byte, empty payload
      directed_rows.push_back(row_none(8'hff));
      directed_rows.push_back(row_none(8'h00));
      directed_rows.push_back(row_err(8'h03, KIND_UNKNOWN, 8'h7f));
      // board dump of two squares, last piece code above twelve
      directed_rows.push_back(row_none(8'h86));
      directed_rows.push_back(row_none(8'h00));
      directed_rows.push_back(row_none(8'h05));
      directed_rows.push_back(row(8'h0c));
      directed_rows.push_back(row(8'h0d));
      // field update naming a square off the board
      directed_rows.push_back(row_none(8'h8e));
      directed_rows.push_back(row_none(8'h00));
      directed_rows.push_back(row_none(8'h04));
      directed_rows.push_back(row_err(8'h40, KIND_BAD_SQUARE, 8'h40));
      // clock frame with a non-bcd byte and both status bits set
      directed_rows.push_back(row_none(8'h8d));
      directed_rows.push_back(row_none(8'h00));
      directed_rows.push_back(row_none(8'h0a));
      directed_rows.push_back(row(8'h09));
      directed_rows.push_back(row(8'h59));
      directed_rows.push_back(row(8'h59));
      directed_rows.push_back(row(8'h00));
      directed_rows.push_back(row(8'hff));
      directed_rows.push_back(row(8'h00));
      directed_rows.push_back(row(8'h03));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_rotation(1'b0);

      foreach (directed_rows[i]) send_byte(directed_rows[i]);
      wait_idle();

      // random phases, alternating the rotation, the last one under a random rotation
      for (int p = 0; p < 5; p++) begin
         if (p == 4)
            set_rotation(1'($urandom_range(0, 1)));
         else
            set_rotation(p[0] ? 1'b0 : 1'b1);
         phase_goal = 26 + 225 * (p + 1);
         while (items_sent < phase_goal) send_random_frame();
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (expected_events.size() != 0)
         report_error($sformatf("%0d results never arrived", expected_events.size()));
      if (error_count == 0)
         $display("chessboard_serial_message_parser_core_tb: clean");
      else
         $display("chessboard_serial_message_parser_core_tb: errors");
      $finish;
   end

endmodule

// ===== chessboard_serial_message_parser_core.f =====
+incdir+hw/rtl
hw/rtl/csmp_pkg.sv
hw/rtl/csmp_fifo.sv
hw/rtl/csmp_front.sv
hw/rtl/csmp_back.sv
hw/rtl/chessboard_serial_message_parser_core.sv
hw/rtl/csmp_checker.sv
sim/chessboard_serial_message_parser_core_tb.sv
